### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the packet ring buffer.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PRB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When trig holds, cond must hold in the next cycle.
`define PRB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/prbdo_pkg.sv
// Package for the packet ring buffer: sizes, field widths, codes and types.
// No dependencies; used by every RTL file of the block but prbdo_ram.
package prbdo_pkg;

  localparam int CAPACITY    = 1024;
  localparam int MAX_PACKETS = 64;

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int QIDX_W = $clog2(MAX_PACKETS);
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1);

  localparam int KIND_W    = 2;
  localparam int LEN_W     = 10;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int USED_W    = 10;
  localparam int HELD_W    = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int SUM_W  = $clog2(CAPACITY + (1 << LEN_W));
  localparam int QSUM_W = CNT_W + 1;

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_OVERWRITE_MODE = '0;

  localparam logic [KIND_W-1:0] KIND_PUSH_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BYTE   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERWRITE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DROP,
    ST_STORE,
    ST_BYTE,
    ST_POP,
    ST_REPLY
  } state_t;

  // Conditions the sequencer branches on.
  typedef struct packed {
    logic              in_fire;
    logic [KIND_W-1:0] kind;
    logic              begin_zero;
    logic              begin_reject;
    logic              need_drop;
    logic              byte_pending;
    logic              pop_empty;
    logic              out_free;
  } fsm_in_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic drop;
    logic store;
    logic byte_wr;
    logic pop;
    logic reply;
  } ctl_t;

endpackage

### rtl/packet_ring_buffer_drop_oldest_core.sv
// Top level of the packet ring buffer with drop-oldest overwrite.
// Depends on prbdo_pkg, prbdo_ram, prbdo_ring_add, prbdo_fsm, assert_macros.svh.

// Variable-length packet FIFO over a 1024-byte ring plus a 64-entry queue of
// packet lengths. Each input transaction is a push_begin (reserve a packet of
// the given length), a push_byte (write the next byte of the open packet) or
// a pop_byte (read the next byte of the oldest packet); each produces exactly
// one result transaction with a status and the occupancy after the item.
// Items are handled one at a time: an item is accepted in idle, then the
// sequencer decides and reads the RAMs, then commits, which registers the
// result. A push_begin in overwrite mode passes through drop and decide once
// more per evicted packet, since eviction re-reads the length RAM for each
// head packet in turn. One ring adder is shared by all pointer updates. The
// commit waits while a previous result is still held on the output, and a new
// item is accepted as soon as the sequencer is back in idle, even if the last
// result is not yet taken. Both RAMs come up undefined and need no clearing
// pass; the block is ready right after reset.
module packet_ring_buffer_drop_oldest_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [prbdo_pkg::IN_TDATA_W-1:0]      in_tdata,   // length[9:0], data[17:10], zero
  input  logic [prbdo_pkg::KIND_W-1:0]          in_tuser,   // kind[1:0]
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // data_out[7:0], bytes_used[17:8], packets_held[24:18], packets_dropped[31:25]
  output logic [prbdo_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [prbdo_pkg::STATUS_W-1:0]        out_tuser,  // status[2:0]
  output logic                                  out_tlast,  // packet_end
  // configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [prbdo_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [prbdo_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [prbdo_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                  cfg_pready
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------- config
  logic mode_r, mode_nxt;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[prbdo_pkg::CFG_AW-1:2] == prbdo_pkg::REG_OVERWRITE_MODE);

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  assign cfg_prdata = cfg_hit ? {{(prbdo_pkg::CFG_DW-1){1'b0}}, mode_r} : '0;

  // ---------------------------------------------------------------- state
  logic [prbdo_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [prbdo_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [prbdo_pkg::DATA_W-1:0] data_r, data_nxt;

  logic [prbdo_pkg::PTR_W-1:0]  rp_r, rp_nxt;        // read pointer
  logic [prbdo_pkg::PTR_W-1:0]  wp_r, wp_nxt;        // write pointer
  logic [prbdo_pkg::PTR_W-1:0]  used_r, used_nxt;    // bytes reserved or stored
  logic [prbdo_pkg::QIDX_W-1:0] head_r, head_nxt;    // length queue head
  logic [prbdo_pkg::CNT_W-1:0]  count_r, count_nxt;  // packets queued
  logic [prbdo_pkg::LEN_W-1:0]  wrem_r, wrem_nxt;    // bytes still to write
  logic [prbdo_pkg::LEN_W-1:0]  hbr_r, hbr_nxt;      // bytes popped from head
  logic [prbdo_pkg::CNT_W-1:0]  drop_cnt_r, drop_cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [prbdo_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [prbdo_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                           out_end_r, out_end_nxt;
  logic [prbdo_pkg::USED_W-1:0]   out_used_r, out_used_nxt;
  logic [prbdo_pkg::HELD_W-1:0]   out_held_r, out_held_nxt;
  logic [prbdo_pkg::HELD_W-1:0]   out_dropped_r, out_dropped_nxt;

  // ---------------------------------------------------------------- sequencer
  prbdo_pkg::fsm_in_t cond;
  prbdo_pkg::ctl_t    ctl;
  logic               in_fire;
  logic               out_free;
  logic               no_room;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = ctl.in_ready;

  // free space <= length  <=>  used + length >= CAPACITY
  assign no_room = (prbdo_pkg::SUM_W'(used_r) + prbdo_pkg::SUM_W'(len_r))
                   >= prbdo_pkg::SUM_W'(prbdo_pkg::CAPACITY);

  always_comb begin
    cond.in_fire      = in_fire;
    cond.kind         = kind_r;
    cond.begin_zero   = (len_r == '0);
    cond.begin_reject = (prbdo_pkg::SUM_W'(len_r) >= prbdo_pkg::SUM_W'(prbdo_pkg::CAPACITY))
                     || (count_r >= prbdo_pkg::CNT_W'(prbdo_pkg::MAX_PACKETS))
                     || (no_room && !mode_r);
    cond.need_drop    = no_room && (count_r != '0);
    cond.byte_pending = (wrem_r != '0);
    cond.pop_empty    = (count_r == '0) || (used_r == '0);
    cond.out_free     = out_free;
  end

  prbdo_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  // ---------------------------------------------------------------- memories
  logic [prbdo_pkg::DATA_W-1:0] bs_rdata;
  logic [prbdo_pkg::LEN_W-1:0]  lq_rdata;   // length of head packet
  logic [prbdo_pkg::QIDX_W-1:0] tail_idx;
  logic [prbdo_pkg::QSUM_W-1:0] tail_sum;

  assign tail_sum = prbdo_pkg::QSUM_W'(head_r) + prbdo_pkg::QSUM_W'(count_r);
  assign tail_idx = (tail_sum >= prbdo_pkg::QSUM_W'(prbdo_pkg::MAX_PACKETS))
                  ? prbdo_pkg::QIDX_W'(tail_sum - prbdo_pkg::QSUM_W'(prbdo_pkg::MAX_PACKETS))
                  : prbdo_pkg::QIDX_W'(tail_sum);

  prbdo_ram #(
    .WIDTH (prbdo_pkg::DATA_W),
    .DEPTH (prbdo_pkg::CAPACITY)
  ) u_byte_store (
    .clk   (clk),
    .we    (ctl.byte_wr),
    .waddr (wp_r),
    .wdata (data_r),
    .re    (ctl.rd_en),
    .raddr (rp_r),
    .rdata (bs_rdata)
  );

  prbdo_ram #(
    .WIDTH (prbdo_pkg::LEN_W),
    .DEPTH (prbdo_pkg::MAX_PACKETS)
  ) u_length_queue (
    .clk   (clk),
    .we    (ctl.store),
    .waddr (tail_idx),
    .wdata (len_r),
    .re    (ctl.rd_en),
    .raddr (head_r),
    .rdata (lq_rdata)
  );

  // ---------------------------------------------------------------- shared adder
  logic [prbdo_pkg::PTR_W-1:0] alu_a, alu_b, alu_sum;
  logic [prbdo_pkg::LEN_W-1:0] left_raw;
  logic [prbdo_pkg::PTR_W-1:0] left;        // unread bytes freed by an eviction
  logic [prbdo_pkg::QIDX_W-1:0] head_inc;
  logic [prbdo_pkg::LEN_W:0]   hbr_inc;
  logic                        pop_end;

  assign left_raw = (lq_rdata > hbr_r) ? (lq_rdata - hbr_r) : '0;
  assign left     = (prbdo_pkg::SUM_W'(left_raw) > prbdo_pkg::SUM_W'(used_r))
                  ? used_r : prbdo_pkg::PTR_W'(left_raw);

  assign head_inc = (head_r == prbdo_pkg::QIDX_W'(prbdo_pkg::MAX_PACKETS - 1))
                  ? '0 : head_r + 1'b1;

  assign hbr_inc = {1'b0, hbr_r} + 1'b1;
  assign pop_end = (hbr_inc >= {1'b0, lq_rdata});

  always_comb begin
    priority if (ctl.drop) begin
      alu_a = rp_r;
      alu_b = left;
    end else if (ctl.pop) begin
      alu_a = rp_r;
      alu_b = prbdo_pkg::PTR_W'(1);
    end else if (ctl.store) begin
      alu_a = wp_r;
      alu_b = prbdo_pkg::PTR_W'(wrem_r);
    end else begin
      alu_a = wp_r;
      alu_b = prbdo_pkg::PTR_W'(1);
    end
  end

  prbdo_ring_add u_ring_add (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  // ---------------------------------------------------------------- datapath
  logic [prbdo_pkg::STATUS_W-1:0] reply_status;

  always_comb begin
    unique case (kind_r)
      prbdo_pkg::KIND_PUSH_BEGIN: reply_status = (len_r == '0) ? prbdo_pkg::STATUS_OK
                                                               : prbdo_pkg::STATUS_REJECT;
      prbdo_pkg::KIND_POP_BYTE:   reply_status = prbdo_pkg::STATUS_EMPTY;
      default:                    reply_status = prbdo_pkg::STATUS_IGNORED;
    endcase
  end

  always_comb begin
    kind_nxt     = kind_r;
    len_nxt      = len_r;
    data_nxt     = data_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    used_nxt     = used_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    wrem_nxt     = wrem_r;
    hbr_nxt      = hbr_r;
    drop_cnt_nxt = drop_cnt_r;

    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_end_nxt     = out_end_r;
    out_dropped_nxt = out_dropped_r;

    if (in_fire) begin
      kind_nxt     = in_tuser;
      len_nxt      = in_tdata[prbdo_pkg::LEN_W-1:0];
      data_nxt     = in_tdata[prbdo_pkg::LEN_W +: prbdo_pkg::DATA_W];
      drop_cnt_nxt = '0;
    end

    if (ctl.drop) begin
      rp_nxt       = alu_sum;
      used_nxt     = used_r - left;
      hbr_nxt      = '0;
      head_nxt     = head_inc;
      count_nxt    = count_r - 1'b1;
      drop_cnt_nxt = drop_cnt_r + 1'b1;
    end

    if (ctl.store) begin
      wp_nxt    = alu_sum;
      wrem_nxt  = len_r;
      count_nxt = count_r + 1'b1;
      used_nxt  = prbdo_pkg::PTR_W'(prbdo_pkg::SUM_W'(used_r) + prbdo_pkg::SUM_W'(len_r));
      out_status_nxt  = (drop_cnt_r != '0) ? prbdo_pkg::STATUS_OVERWRITE : prbdo_pkg::STATUS_OK;
      out_data_nxt    = '0;
      out_end_nxt     = 1'b0;
      out_dropped_nxt = prbdo_pkg::HELD_W'(drop_cnt_r);
    end

    if (ctl.byte_wr) begin
      wp_nxt   = alu_sum;
      wrem_nxt = wrem_r - 1'b1;
      out_status_nxt  = prbdo_pkg::STATUS_OK;
      out_data_nxt    = '0;
      out_end_nxt     = 1'b0;
      out_dropped_nxt = '0;
    end

    if (ctl.pop) begin
      rp_nxt   = alu_sum;
      used_nxt = used_r - 1'b1;
      if (pop_end) begin
        hbr_nxt   = '0;
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
      end else begin
        hbr_nxt = prbdo_pkg::LEN_W'(hbr_inc);
      end
      out_status_nxt  = prbdo_pkg::STATUS_OK;
      out_data_nxt    = bs_rdata;
      out_end_nxt     = pop_end;
      out_dropped_nxt = '0;
    end

    if (ctl.reply) begin
      out_status_nxt  = reply_status;
      out_data_nxt    = '0;
      out_end_nxt     = 1'b0;
      out_dropped_nxt = '0;
    end

    // Occupancy fields report the state after the item.
    out_used_nxt = prbdo_pkg::USED_W'(used_nxt);
    out_held_nxt = prbdo_pkg::HELD_W'(count_nxt);
    if (!(ctl.store || ctl.byte_wr || ctl.pop || ctl.reply)) begin
      out_used_nxt = out_used_r;
      out_held_nxt = out_held_r;
    end

    priority if (ctl.store || ctl.byte_wr || ctl.pop || ctl.reply) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      rp_r        <= '0;
      wp_r        <= '0;
      used_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      wrem_r      <= '0;
      hbr_r       <= '0;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      wrem_r      <= wrem_nxt;
      hbr_r       <= hbr_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    len_r         <= len_nxt;
    data_r        <= data_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_end_r     <= out_end_nxt;
    out_used_r    <= out_used_nxt;
    out_held_r    <= out_held_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_end_r;
  assign out_tdata  = {out_dropped_r, out_held_r, out_used_r, out_data_r};

  // ---------------------------------------------------------------- checks
  `PRB_ASSERT(a_count_bound, count_r <= prbdo_pkg::CNT_W'(prbdo_pkg::MAX_PACKETS), "queue count over limit")
  `PRB_ASSERT(a_drop_mode, !ctl.drop || mode_r, "eviction outside overwrite mode")
  `PRB_ASSERT(a_pop_nonempty, !ctl.pop || ((count_r != '0) && (used_r != '0)), "pop on empty ring")
  `PRB_ASSERT(a_no_clobber, !(out_valid_r && !out_tready) || !(ctl.store || ctl.byte_wr || ctl.pop || ctl.reply), "result overwritten while held")
  `PRB_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "accepted while busy")

endmodule

### rtl/prbdo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prbdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/prbdo_ring_add.sv
// Shared ring-pointer adder: (a + b) mod CAPACITY for a, b below CAPACITY.
// Depends on prbdo_pkg.
module prbdo_ring_add (
  input  logic [prbdo_pkg::PTR_W-1:0] a,
  input  logic [prbdo_pkg::PTR_W-1:0] b,
  output logic [prbdo_pkg::PTR_W-1:0] sum
);

  logic [prbdo_pkg::PTR_W:0] raw;

  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    if (raw >= (prbdo_pkg::PTR_W + 1)'(prbdo_pkg::CAPACITY)) begin
      sum = prbdo_pkg::PTR_W'(raw - (prbdo_pkg::PTR_W + 1)'(prbdo_pkg::CAPACITY));
    end else begin
      sum = prbdo_pkg::PTR_W'(raw);
    end
  end

endmodule

### rtl/prbdo_fsm.sv
// Sequencer of the packet ring buffer: one item at a time, eviction loop.
// Depends on prbdo_pkg.
module prbdo_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  prbdo_pkg::fsm_in_t cond,
  output prbdo_pkg::ctl_t    ctl
);

  prbdo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prbdo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prbdo_pkg::ST_IDLE: begin
        if (cond.in_fire) state_nxt = prbdo_pkg::ST_DECIDE;
      end
      prbdo_pkg::ST_DECIDE: begin
        unique case (cond.kind)
          prbdo_pkg::KIND_PUSH_BEGIN: begin
            priority if (cond.begin_zero || cond.begin_reject) state_nxt = prbdo_pkg::ST_REPLY;
            else if (cond.need_drop) state_nxt = prbdo_pkg::ST_DROP;
            else state_nxt = prbdo_pkg::ST_STORE;
          end
          prbdo_pkg::KIND_PUSH_BYTE: begin
            state_nxt = cond.byte_pending ? prbdo_pkg::ST_BYTE : prbdo_pkg::ST_REPLY;
          end
          prbdo_pkg::KIND_POP_BYTE: begin
            state_nxt = cond.pop_empty ? prbdo_pkg::ST_REPLY : prbdo_pkg::ST_POP;
          end
          default: state_nxt = prbdo_pkg::ST_REPLY;
        endcase
      end
      prbdo_pkg::ST_DROP: state_nxt = prbdo_pkg::ST_DECIDE;
      prbdo_pkg::ST_STORE, prbdo_pkg::ST_BYTE, prbdo_pkg::ST_POP,
      prbdo_pkg::ST_REPLY: begin
        if (cond.out_free) state_nxt = prbdo_pkg::ST_IDLE;
      end
      default: state_nxt = prbdo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      prbdo_pkg::ST_IDLE:   ctl.in_ready = 1'b1;
      prbdo_pkg::ST_DECIDE: ctl.rd_en    = 1'b1;
      prbdo_pkg::ST_DROP:   ctl.drop     = 1'b1;
      prbdo_pkg::ST_STORE:  ctl.store    = cond.out_free;
      prbdo_pkg::ST_BYTE:   ctl.byte_wr  = cond.out_free;
      prbdo_pkg::ST_POP:    ctl.pop      = cond.out_free;
      prbdo_pkg::ST_REPLY:  ctl.reply    = cond.out_free;
      default:              ctl = '0;
    endcase
  end

endmodule

### verif/packet_ring_buffer_drop_oldest_core_tb.sv
// Self-checking testbench for packet_ring_buffer_drop_oldest_core.
// Needs prbdo_pkg and the block's RTL; plans stimulus and predicts results
// with its own model of the packet ring.
module packet_ring_buffer_drop_oldest_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [prbdo_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;  // undefined kind, ignored
  localparam int PLAN = 0;              // model copy used to plan legal stimulus
  localparam int LIVE = 1;              // model copy fed from accepted transactions
  localparam int RANDOM_OPS = 210;      // random transactions per phase
  localparam int BURST_PACKETS = 66;    // enough to overrun the length queue
  // Slowest transaction: a push_begin that evicts 63 packets, with stalls on
  // both sides on top. Far above any quiet stretch of a working block.
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [prbdo_pkg::KIND_W-1:0] kind;
    logic [prbdo_pkg::LEN_W-1:0]  length;
    logic [prbdo_pkg::DATA_W-1:0] data;
  } ring_op_t;

  typedef struct packed {
    logic [prbdo_pkg::STATUS_W-1:0] status;
    logic [prbdo_pkg::DATA_W-1:0]   data_out;
    logic                           packet_end;
    logic [prbdo_pkg::USED_W-1:0]   bytes_used;
    logic [prbdo_pkg::HELD_W-1:0]   packets_held;
    logic [prbdo_pkg::HELD_W-1:0]   packets_dropped;
  } ring_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [prbdo_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // length[9:0], data[17:10], zero
  logic [prbdo_pkg::KIND_W-1:0] in_tuser = '0;       // kind[1:0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  // data_out[7:0], bytes_used[17:8], packets_held[24:18], packets_dropped[31:25]
  logic [prbdo_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [prbdo_pkg::STATUS_W-1:0] out_tuser;         // status[2:0]
  logic out_tlast;                                   // packet_end
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [prbdo_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [prbdo_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [prbdo_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  packet_ring_buffer_drop_oldest_core i_dut (.*);

  // Two copies of the ring state, indexed by PLAN / LIVE.
  logic [prbdo_pkg::DATA_W-1:0] ring_mem [2][prbdo_pkg::CAPACITY];
  bit                ring_written [2][prbdo_pkg::CAPACITY];
  int                len_fifo [2][prbdo_pkg::MAX_PACKETS];
  int rd_ptr [2] = '{0, 0};
  int wr_ptr [2] = '{0, 0};
  int used [2] = '{0, 0};
  int qhead [2] = '{0, 0};
  int qcount [2] = '{0, 0};
  int wr_left [2] = '{0, 0};
  int head_read [2] = '{0, 0};
  bit ovw_mode [2] = '{1'b0, 1'b0};

  ring_op_t    pending_ops [$];
  ring_reply_t ring_replies_due [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Advance one model copy by one transaction and return its reply.
  function automatic ring_reply_t ring_apply(int s, ring_op_t op);
    ring_reply_t rep;
    int len;
    int left;
    int dropped;
    rep = '0;
    rep.status = prbdo_pkg::STATUS_IGNORED;
    len = int'(op.length);
    dropped = 0;
    case (op.kind)
      prbdo_pkg::KIND_PUSH_BEGIN: begin
        if (len >= prbdo_pkg::CAPACITY) begin
          rep.status = prbdo_pkg::STATUS_REJECT;
        end else if (len == 0) begin
          rep.status = prbdo_pkg::STATUS_OK;
        end else if (qcount[s] >= prbdo_pkg::MAX_PACKETS) begin
          rep.status = prbdo_pkg::STATUS_REJECT;
        end else if (prbdo_pkg::CAPACITY - used[s] <= len && !ovw_mode[s]) begin
          rep.status = prbdo_pkg::STATUS_REJECT;
        end else begin
          // evict whole head packets; a partly read head frees only its unread bytes
          while (prbdo_pkg::CAPACITY - used[s] <= len && qcount[s] > 0) begin
            left = len_fifo[s][qhead[s]] - head_read[s];
            if (left < 0) left = 0;
            if (left > used[s]) left = used[s];
            rd_ptr[s] = (rd_ptr[s] + left) % prbdo_pkg::CAPACITY;
            used[s] -= left;
            head_read[s] = 0;
            qhead[s] = (qhead[s] + 1) % prbdo_pkg::MAX_PACKETS;
            qcount[s] -= 1;
            dropped += 1;
          end
          rep.status = (dropped > 0) ? prbdo_pkg::STATUS_OVERWRITE : prbdo_pkg::STATUS_OK;
          // bytes still owed by the open packet are skipped over
          wr_ptr[s] = (wr_ptr[s] + wr_left[s]) % prbdo_pkg::CAPACITY;
          wr_left[s] = len;
          len_fifo[s][(qhead[s] + qcount[s]) % prbdo_pkg::MAX_PACKETS] = len;
          qcount[s] += 1;
          used[s] += len;
        end
      end
      prbdo_pkg::KIND_PUSH_BYTE: begin
        if (wr_left[s] > 0) begin
          ring_mem[s][wr_ptr[s]] = op.data;
          ring_written[s][wr_ptr[s]] = 1'b1;
          wr_ptr[s] = (wr_ptr[s] + 1) % prbdo_pkg::CAPACITY;
          wr_left[s] -= 1;
          rep.status = prbdo_pkg::STATUS_OK;
        end
      end
      prbdo_pkg::KIND_POP_BYTE: begin
        if (qcount[s] == 0 || used[s] == 0) begin
          rep.status = prbdo_pkg::STATUS_EMPTY;
        end else begin
          rep.data_out = ring_mem[s][rd_ptr[s]];
          rd_ptr[s] = (rd_ptr[s] + 1) % prbdo_pkg::CAPACITY;
          used[s] -= 1;
          head_read[s] += 1;
          rep.status = prbdo_pkg::STATUS_OK;
          if (head_read[s] >= len_fifo[s][qhead[s]]) begin
            rep.packet_end = 1'b1;
            head_read[s] = 0;
            qhead[s] = (qhead[s] + 1) % prbdo_pkg::MAX_PACKETS;
            qcount[s] -= 1;
          end
        end
      end
      default: ;
    endcase
    rep.bytes_used = prbdo_pkg::USED_W'(used[s]);
    rep.packets_held = prbdo_pkg::HELD_W'(qcount[s]);
    rep.packets_dropped = prbdo_pkg::HELD_W'(dropped);
    return rep;
  endfunction

  // A pop that would read a ring slot never written is illegal stimulus.
  function automatic bit pop_hits_blank_slot();
    return qcount[PLAN] != 0 && used[PLAN] != 0 && !ring_written[PLAN][rd_ptr[PLAN]];
  endfunction

  task automatic queue_op(logic [prbdo_pkg::KIND_W-1:0] kind, int length, int data);
    ring_op_t op;
    op.kind = kind;
    op.length = prbdo_pkg::LEN_W'(length);
    op.data = prbdo_pkg::DATA_W'(data);
    if (kind == prbdo_pkg::KIND_POP_BYTE && pop_hits_blank_slot())
      op.kind = prbdo_pkg::KIND_PUSH_BYTE;
    void'(ring_apply(PLAN, op));
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Mostly short packets; some long ones and some sized right at the free space.
  function automatic int pick_length();
    int r;
    int room;
    int v;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 58) return $urandom_range(1, 16);
    if (r < 78) return $urandom_range(17, 96);
    if (r < 86) return $urandom_range(97, 400);
    if (r < 92) return $urandom_range(401, 1023);
    room = prbdo_pkg::CAPACITY - used[PLAN];
    v = $urandom_range(room - 1, room);
    if (v < 1) v = 1;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic gen_step();
    int r;
    r = $urandom_range(0, 99);
    if (wr_left[PLAN] > 0) begin
      if (r < 72)
        queue_op(prbdo_pkg::KIND_PUSH_BYTE, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (r < 92)
        queue_op(prbdo_pkg::KIND_POP_BYTE, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (r < 96)
        queue_op(prbdo_pkg::KIND_PUSH_BEGIN, pick_length(), $urandom_range(0, 255));
      else
        queue_op(KIND_RESERVED, $urandom_range(0, 1023), $urandom_range(0, 255));
    end else begin
      if (r < 40)
        queue_op(prbdo_pkg::KIND_PUSH_BEGIN, pick_length(), $urandom_range(0, 255));
      else if (r < 80)
        queue_op(prbdo_pkg::KIND_POP_BYTE, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if (r < 90)
        queue_op(prbdo_pkg::KIND_PUSH_BYTE, $urandom_range(0, 1023), $urandom_range(0, 255));
      else
        queue_op(KIND_RESERVED, $urandom_range(0, 1023), $urandom_range(0, 255));
    end
  endtask

  // Tiny complete packets until the length queue overflows.
  task automatic fill_length_queue();
    repeat (BURST_PACKETS) begin
      queue_op(prbdo_pkg::KIND_PUSH_BEGIN, $urandom_range(1, 2), $urandom_range(0, 255));
      while (wr_left[PLAN] != 0)
        queue_op(prbdo_pkg::KIND_PUSH_BYTE, $urandom_range(0, 1023), $urandom_range(0, 255));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || ring_replies_due.size() != 0);
  endtask

  // APB write of the mode register, only once the block has gone quiet.
  task automatic set_overwrite_mode(bit value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {prbdo_pkg::REG_OVERWRITE_MODE, 2'b00};
    cfg_pwdata <= prbdo_pkg::CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    ovw_mode[PLAN] = value;
    ovw_mode[LIVE] = value;
  endtask

  task automatic run_phase(bit mode, int send_pct, int recv_pct, bit burst);
    set_overwrite_mode(mode);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (burst) fill_length_queue();
    repeat (RANDOM_OPS / 2) gen_step();
    // sender holds off until every outstanding reply is back
    wait_drained();
    repeat (RANDOM_OPS - RANDOM_OPS / 2) gen_step();
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  // Sender: hold the transaction until taken, random gaps between transactions.
  always @(posedge clk) begin : drive_ops
    ring_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= prbdo_pkg::IN_TDATA_W'({nxt.data, nxt.length});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on each accepted input, compare each accepted reply.
  always @(posedge clk) begin : watch_ring
    ring_op_t op;
    ring_reply_t want;
    ring_reply_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        op.kind = in_tuser;
        op.length = in_tdata[prbdo_pkg::LEN_W-1:0];
        op.data = in_tdata[prbdo_pkg::LEN_W +: prbdo_pkg::DATA_W];
        ring_replies_due.insert(ring_replies_due.size(), ring_apply(LIVE, op));
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.packet_end = out_tlast;
        got.data_out = out_tdata[prbdo_pkg::DATA_W-1:0];
        got.bytes_used = out_tdata[prbdo_pkg::DATA_W +: prbdo_pkg::USED_W];
        got.packets_held =
          out_tdata[prbdo_pkg::DATA_W + prbdo_pkg::USED_W +: prbdo_pkg::HELD_W];
        got.packets_dropped = out_tdata[prbdo_pkg::DATA_W + prbdo_pkg::USED_W
                                        + prbdo_pkg::HELD_W +: prbdo_pkg::HELD_W];
        if (ring_replies_due.size() == 0) begin
          note_mismatch("unexpected reply", '0, 32'(got.status));
        end else begin
          want = ring_replies_due.pop_front();
          if (want.status !== got.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          if (want.data_out !== got.data_out)
            note_mismatch("data_out", 32'(want.data_out), 32'(got.data_out));
          if (want.packet_end !== got.packet_end)
            note_mismatch("packet_end", 32'(want.packet_end), 32'(got.packet_end));
          if (want.bytes_used !== got.bytes_used)
            note_mismatch("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
          if (want.packets_held !== got.packets_held)
            note_mismatch("packets_held", 32'(want.packets_held), 32'(got.packets_held));
          if (want.packets_dropped !== got.packets_dropped)
            note_mismatch("packets_dropped", 32'(want.packets_dropped),
                          32'(got.packets_dropped));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // skip mode: empty pop, stray byte, undefined kind, zero length, byte extremes
    set_overwrite_mode(1'b0);
    queue_op(prbdo_pkg::KIND_POP_BYTE, 0, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 1023, 8'h5a);
    queue_op(KIND_RESERVED, 0, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 0, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 3, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'h00);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'hff);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'ha5);
    repeat (3) queue_op(prbdo_pkg::KIND_POP_BYTE, 0, 0);
    // partly written packet popped early, then abandoned by the next begin
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 2, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'h81);
    queue_op(prbdo_pkg::KIND_POP_BYTE, 0, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 1020, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 5, 0);      // no room: rejected
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 2, 0);      // fills to 1023 bytes
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 1, 0);      // one byte free, still rejected

    // overwrite mode: multi-packet eviction, partly read head evicted
    set_overwrite_mode(1'b1);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 100, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'h3c);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'hc3);
    queue_op(prbdo_pkg::KIND_POP_BYTE, 0, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 1023, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BEGIN, 1, 0);
    queue_op(prbdo_pkg::KIND_PUSH_BYTE, 0, 8'h77);
    queue_op(prbdo_pkg::KIND_POP_BYTE, 0, 0);

    run_phase(1'b0, 0, 0, 1'b0);
    run_phase(1'b1, 53, 0, 1'b0);
    run_phase(1'b0, 0, 53, 1'b1);
    run_phase(1'b1, 31, 31, 1'b1);
    run_phase(1'b1, 0, 0, 1'b0);
    run_phase(1'b0, 31, 31, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && ring_replies_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/prbdo_pkg.sv
rtl/prbdo_ram.sv
rtl/prbdo_ring_add.sv
rtl/prbdo_fsm.sv
rtl/packet_ring_buffer_drop_oldest_core.sv
verif/packet_ring_buffer_drop_oldest_core_tb.sv
